// ===== hdl/jsp_pkg.sv =====
// Shared types and constants of the Julia set pixel engine.
package jsp_pkg;

  // Pixel coordinate width and configuration port widths.
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned SIDE_W    = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Register indices of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_HIGH    = 3'd5;

  // Reset values of the configuration registers (window of -1.5 to 1.5).
  localparam logic [SIDE_W-1:0]   RST_SIDE   = 13'd1000;
  localparam logic signed [31:0]  RST_LOW    = -32'sd1572864;
  localparam logic signed [31:0]  RST_HIGH   = 32'sd1572864;

  // Q12.20 limits and the Julia constant c = -0.5 + 0.5i.
  localparam logic [31:0]         Q_MAX_U    = 32'h7FFF_FFFF;
  localparam logic [31:0]         Q_MIN_U    = 32'h8000_0000;
  localparam logic [32:0]         Q_MIN_MAG  = 33'h0_8000_0000;
  localparam logic signed [31:0]  C_RE       = -32'sd524288;
  localparam logic signed [31:0]  C_IM       = 32'sd524288;

  // Escape threshold on |z|^2 in Q24.40.
  localparam logic [63:0]         ESC_LIMIT  = 64'd1000 << 40;

  // Full colour channel value.
  localparam logic [7:0]          COLOUR_FULL = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_px;   // capture the pixel position
    logic map_num;   // form the mapping numerator for the selected axis
    logic div_init;  // load the divider with the numerator magnitude
    logic div_step;  // one restoring division step
    logic store;     // store the saturated quotient as start value
    logic axis;      // 0: real axis, 1: imaginary axis
    logic mul;       // register the three products of z
    logic upd;       // update z from the registered products
    logic out_load;  // load the result register
    logic in_set;    // result flag to load
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escape;    // |z|^2 of the registered products exceeds the limit
  } sts_t;

endpackage

// ===== hdl/julia_set_pixel.sv =====
// Top level of the Julia set pixel engine: stream ports and configuration port.
// Each item is mapped on both axes by a restoring divider of DIV_STEPS steps, 45 at
// MAX_SIDE 4096, then iterated for n rounds until escape (MAX_ROUNDS if none). One item is in
// work at a time; its result waits in the output register while the next item is accepted.
// Reset is asynchronous and active low; it restores the default window and empties the block.
module julia_set_pixel #(
  parameter int unsigned MAX_SIDE   = 4096,
  parameter int unsigned MAX_ROUNDS = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,     // column[11:0], row[23:12]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,     // in_set[0], red[8:1], green[16:9],
                                                         // blue[24:17], zero[31:25]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [jsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [jsp_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned DW = $clog2(MAX_SIDE);
  localparam int unsigned PW = (DW > jsp_pkg::PIX_W) ? DW : jsp_pkg::PIX_W;
  localparam int unsigned NW = PW + 33;

  jsp_pkg::cmd_t cmd;
  jsp_pkg::sts_t sts;
  logic          in_set;
  logic [7:0]    rg;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  jsp_ctrl #(
    .DIV_STEPS  (NW),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  jsp_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .col_i       (s_tdata[11:0]),
    .row_i       (s_tdata[23:12]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_set_o    (in_set)
  );

  // Points in the set are blue, escaping points white.
  assign rg      = in_set ? 8'd0 : jsp_pkg::COLOUR_FULL;
  assign m_tdata = {7'd0, jsp_pkg::COLOUR_FULL, rg, rg, in_set};

endmodule

// ===== hdl/jsp_ctrl.sv =====
// Sequencer of the Julia set pixel engine: mapping, division and iteration.
module jsp_ctrl #(
  parameter int unsigned DIV_STEPS  = 45,
  parameter int unsigned MAX_ROUNDS = 1000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output jsp_pkg::cmd_t cmd_o,
  input  jsp_pkg::sts_t sts_i
);

  localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned CW = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic          axis_q, axis_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [CW-1:0] dcnt_q, dcnt_d;
  logic          set_q, set_d;
  logic          vld_q, vld_d;
  logic          out_free;

  // The result register can take a new item when empty or being drained.
  assign out_free = !vld_q || m_tready;
  assign s_tready = (state_q == S_IDLE);
  assign m_tvalid = vld_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    rnd_d   = rnd_q;
    dcnt_d  = dcnt_q;
    set_d   = set_q;
    vld_d   = vld_q && !m_tready;
    cmd_o   = '0;
    cmd_o.axis   = axis_q;
    cmd_o.in_set = set_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_o.load_px = 1'b1;
          axis_d  = 1'b0;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map_num = 1'b1;
        state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d = dcnt_q + CW'(1);
        if (dcnt_q == CW'(DIV_STEPS - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_MAP;
        end else begin
          rnd_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        // The escape test applies to z after an update, never to the start value.
        if ((rnd_q != '0) && sts_i.escape) begin
          set_d   = 1'b0;
          state_d = S_FIN;
        end else if (rnd_q == RW'(MAX_ROUNDS)) begin
          set_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.upd = 1'b1;
          rnd_d   = rnd_q + RW'(1);
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          vld_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
      rnd_q   <= '0;
      dcnt_q  <= '0;
      set_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      rnd_q   <= rnd_d;
      dcnt_q  <= dcnt_d;
      set_q   <= set_d;
      vld_q   <= vld_d;
    end
  end

endmodule

// ===== hdl/jsp_dpath.sv =====
// Datapath of the Julia set pixel engine: configuration, mapping divider and z iteration.
module jsp_dpath #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jsp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [jsp_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic [jsp_pkg::PIX_W-1:0]           col_i,
  input  logic [jsp_pkg::PIX_W-1:0]           row_i,
  input  jsp_pkg::cmd_t                       cmd_i,
  output jsp_pkg::sts_t                       sts_o,
  output logic                                in_set_o
);

  // Divisor width, position width and numerator widths.
  localparam int unsigned DW = $clog2(MAX_SIDE);
  localparam int unsigned PW = (DW > jsp_pkg::PIX_W) ? DW : jsp_pkg::PIX_W;
  localparam int unsigned MW = PW + 33;
  localparam int unsigned NS = PW + 34;
  localparam int unsigned NW = NS - 1;

  logic [jsp_pkg::SIDE_W-1:0] width_q, height_q;
  logic signed [31:0]         rlo_q, rhi_q, ilo_q, ihi_q;
  logic [jsp_pkg::PIX_W-1:0]  col_q, row_q;
  logic signed [NS-1:0]       num_q;
  logic [NW-1:0]              quo_q;
  logic [DW-1:0]              rem_q;
  logic                       neg_q;
  logic signed [31:0]         re_q, im_q;
  logic signed [63:0]         rr_q, ii_q, ri_q;
  logic                       in_set_q;

  // Clamp a side length and return it minus one.
  function automatic logic [DW-1:0] side_div(input logic [jsp_pkg::SIDE_W-1:0] n);
    logic [DW-1:0] r;
    if (n < jsp_pkg::SIDE_W'(2)) begin
      r = DW'(1);
    end else if ({4'b0, n} > 17'(MAX_SIDE)) begin
      r = DW'(MAX_SIDE - 1);
    end else begin
      r = DW'(n - jsp_pkg::SIDE_W'(1));
    end
    return r;
  endfunction

  // Saturate a wide signed value to Q12.20.
  function automatic logic [31:0] sat_q(input logic signed [45:0] v);
    logic [31:0] r;
    if (v > 46'sd2147483647) begin
      r = jsp_pkg::Q_MAX_U;
    end else if (v < -46'sd2147483648) begin
      r = jsp_pkg::Q_MIN_U;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= jsp_pkg::RST_SIDE;
      height_q <= jsp_pkg::RST_SIDE;
      rlo_q    <= jsp_pkg::RST_LOW;
      rhi_q    <= jsp_pkg::RST_HIGH;
      ilo_q    <= jsp_pkg::RST_LOW;
      ihi_q    <= jsp_pkg::RST_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jsp_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[jsp_pkg::SIDE_W-1:0];
        jsp_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[jsp_pkg::SIDE_W-1:0];
        jsp_pkg::CFG_REAL_LOW:     rlo_q    <= $signed(cfg_data_i);
        jsp_pkg::CFG_REAL_HIGH:    rhi_q    <= $signed(cfg_data_i);
        jsp_pkg::CFG_IMAG_LOW:     ilo_q    <= $signed(cfg_data_i);
        jsp_pkg::CFG_IMAG_HIGH:    ihi_q    <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Mapping numerator: (d - p) * low + p * high for the selected axis.
  logic [DW-1:0]              d_sel;
  logic [jsp_pkg::PIX_W-1:0]  p_sel;
  logic signed [31:0]         lo_sel, hi_sel;
  logic signed [PW:0]         diff_s, pos_s;
  logic signed [PW+32:0]      p_lo, p_hi;
  logic signed [NS-1:0]       num_d;

  assign d_sel  = cmd_i.axis ? side_div(height_q) : side_div(width_q);
  assign p_sel  = cmd_i.axis ? row_q : col_q;
  assign lo_sel = cmd_i.axis ? ilo_q : rlo_q;
  assign hi_sel = cmd_i.axis ? ihi_q : rhi_q;
  assign pos_s  = $signed({1'b0, PW'(p_sel)});
  assign diff_s = $signed({1'b0, PW'(d_sel)}) - pos_s;
  assign p_lo   = MW'(diff_s) * MW'(lo_sel);
  assign p_hi   = MW'(pos_s) * MW'(hi_sel);
  assign num_d  = NS'(p_lo) + NS'(p_hi);

  // Restoring division step on the numerator magnitude.
  logic [DW:0]   rem_sh;
  logic [DW+1:0] trial;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, d_sel};

  // Quotient with sign and saturation.
  logic [31:0] q_store;

  always_comb begin
    if (!neg_q) begin
      q_store = (quo_q > NW'(jsp_pkg::Q_MAX_U)) ? jsp_pkg::Q_MAX_U : quo_q[31:0];
    end else begin
      q_store = (quo_q > NW'(jsp_pkg::Q_MIN_MAG)) ? jsp_pkg::Q_MIN_U : (32'd0 - quo_q[31:0]);
    end
  end

  // Iteration update and escape test.
  logic signed [63:0] rr_ii;
  logic signed [45:0] nre_w, nim_w;
  logic [63:0]        mag;

  assign rr_ii = rr_q - ii_q;
  assign nre_w = 46'($signed(rr_ii[63:20])) + 46'(jsp_pkg::C_RE);
  assign nim_w = 46'($signed(ri_q[63:19])) + 46'(jsp_pkg::C_IM);
  assign mag   = {1'b0, rr_q[62:0]} + {1'b0, ii_q[62:0]};
  assign sts_o.escape = (mag > jsp_pkg::ESC_LIMIT);

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (cmd_i.map_num) begin
      num_q <= num_d;
    end
    if (cmd_i.div_init) begin
      neg_q <= num_q[NS-1];
      quo_q <= num_q[NS-1] ? NW'(-num_q) : NW'(num_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[DW+1]) begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (cmd_i.store) begin
      if (cmd_i.axis) begin
        im_q <= $signed(q_store);
      end else begin
        re_q <= $signed(q_store);
      end
    end else if (cmd_i.upd) begin
      re_q <= $signed(sat_q(nre_w));
      im_q <= $signed(sat_q(nim_w));
    end
    // Signed 32 by 32 products, kept at full width.
    if (cmd_i.mul) begin
      rr_q <= 64'(re_q) * 64'(re_q);
      ii_q <= 64'(im_q) * 64'(im_q);
      ri_q <= 64'(re_q) * 64'(im_q);
    end
    if (cmd_i.out_load) begin
      in_set_q <= cmd_i.in_set;
    end
  end

  assign in_set_o = in_set_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the Julia set pixel engine with its own escape-time predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 3;
  localparam int MAX_IDLE      = 10;
  localparam int DRAIN_SLACK   = 16;
  localparam int TARGET_PIXELS = 570;
  localparam int MAX_PRINTED   = 50;
  // Limit for the whole run: worst case per pixel plus both idle draws, taken four times over.
  localparam int CYCLE_LIMIT   = 5_000_000;

  // Q12.20 values used by the predictor and the stimulus.
  localparam int unsigned SIDE_LIMIT = 4096;
  localparam int unsigned ROUNDS     = 1000;
  localparam longint      Q_TOP      = 64'sd2147483647;
  localparam longint      Q_BOTTOM   = -64'sd2147483648;
  localparam longint      JULIA_RE   = -64'sd524288;
  localparam longint      JULIA_IM   = 64'sd524288;
  localparam longint unsigned ESCAPE_MAG = 64'd1000 << 40;
  localparam int          Q_ONE      = 1 << 20;

  // Expected colour of one pixel, with its position for messages.
  typedef struct packed {
    logic [jsp_pkg::PIX_W-1:0] column;
    logic [jsp_pkg::PIX_W-1:0] row;
    logic                      in_set;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
  } pixel_colour_t;

  // Scoreboard: keeps a copy of the window registers and the queue of expected pixels.
  class pixel_scoreboard;
    logic [jsp_pkg::SIDE_W-1:0] width_reg;
    logic [jsp_pkg::SIDE_W-1:0] height_reg;
    longint            real_lo;
    longint            real_hi;
    longint            imag_lo;
    longint            imag_hi;
    pixel_colour_t     pending_pixels[$];
    int                errors;
    int                printed;
    int                pixels_seen;
    int                inside_seen;

    function new();
      width_reg   = jsp_pkg::RST_SIDE;
      height_reg  = jsp_pkg::RST_SIDE;
      real_lo     = jsp_pkg::RST_LOW;
      real_hi     = jsp_pkg::RST_HIGH;
      imag_lo     = jsp_pkg::RST_LOW;
      imag_hi     = jsp_pkg::RST_HIGH;
      errors      = 0;
      printed     = 0;
      pixels_seen = 0;
      inside_seen = 0;
    endfunction

    function void set_reg(logic [jsp_pkg::CFG_IDX_W-1:0] index,
                          logic [jsp_pkg::CFG_DAT_W-1:0] data);
      case (index)
        jsp_pkg::CFG_IMAGE_WIDTH:  width_reg  = data[jsp_pkg::SIDE_W-1:0];
        jsp_pkg::CFG_IMAGE_HEIGHT: height_reg = data[jsp_pkg::SIDE_W-1:0];
        jsp_pkg::CFG_REAL_LOW:     real_lo    = $signed(data);
        jsp_pkg::CFG_REAL_HIGH:    real_hi    = $signed(data);
        jsp_pkg::CFG_IMAG_LOW:     imag_lo    = $signed(data);
        jsp_pkg::CFG_IMAG_HIGH:    imag_hi    = $signed(data);
        default: ;
      endcase
    endfunction

    // Sizes below two act as two, sizes above the limit act as the limit.
    function int unsigned eff_side(logic [jsp_pkg::SIDE_W-1:0] raw);
      if (raw < 2) return 2;
      if (raw > SIDE_LIMIT) return SIDE_LIMIT;
      return 32'(raw);
    endfunction

    function longint clamp_q(longint v);
      if (v > Q_TOP) return Q_TOP;
      if (v < Q_BOTTOM) return Q_BOTTOM;
      return v;
    endfunction

    // Linear map of a pixel position onto the window, truncating division.
    function longint map_axis(int unsigned pos, int unsigned n, longint lo, longint hi);
      longint d;
      longint p;
      longint num;
      d   = longint'(n) - 1;
      p   = longint'(pos);
      num = (d - p) * lo + p * hi;
      return clamp_q(num / d);
    endfunction

    // Escape-time test of z -> z^2 + c from the mapped start point.
    function logic stays_bounded(longint re0, longint im0);
      longint re;
      longint im;
      longint rr;
      longint ii;
      longint ri;
      longint nre;
      longint nim;
      longint unsigned mag;
      re = re0;
      im = im0;
      for (int k = 0; k < ROUNDS; k++) begin
        rr  = re * re;
        ii  = im * im;
        ri  = re * im;
        nre = clamp_q(((rr - ii) >>> 20) + JULIA_RE);
        nim = clamp_q((ri >>> 19) + JULIA_IM);
        re  = nre;
        im  = nim;
        mag = longint'(re * re) + longint'(im * im);
        if (mag > ESCAPE_MAG) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_pixel(logic [jsp_pkg::PIX_W-1:0] column,
                             logic [jsp_pkg::PIX_W-1:0] row);
      pixel_colour_t px;
      longint        re0;
      longint        im0;
      re0       = map_axis(column, eff_side(width_reg), real_lo, real_hi);
      im0       = map_axis(row, eff_side(height_reg), imag_lo, imag_hi);
      px.column = column;
      px.row    = row;
      px.in_set = stays_bounded(re0, im0);
      px.red    = px.in_set ? 8'd0 : 8'd255;
      px.green  = px.in_set ? 8'd0 : 8'd255;
      px.blue   = 8'd255;
      pending_pixels.push_back(px);
      pixels_seen++;
      if (px.in_set) inside_seen++;
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction

    task report(string msg);
      errors++;
      if (printed < MAX_PRINTED) begin
        printed++;
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    // Compare one result item with the oldest expected pixel, field by field.
    task check_pixel(logic [31:0] word);
      pixel_colour_t px;
      if (pending_pixels.size() == 0) begin
        report($sformatf("result %h arrived with no pixel waiting", word));
        return;
      end
      px = pending_pixels.pop_front();
      if (word[0] !== px.in_set)
        report($sformatf("pixel (%0d,%0d) in_set %b, expected %b",
                         px.column, px.row, word[0], px.in_set));
      if (word[8:1] !== px.red)
        report($sformatf("pixel (%0d,%0d) red %0d, expected %0d",
                         px.column, px.row, word[8:1], px.red));
      if (word[16:9] !== px.green)
        report($sformatf("pixel (%0d,%0d) green %0d, expected %0d",
                         px.column, px.row, word[16:9], px.green));
      if (word[24:17] !== px.blue)
        report($sformatf("pixel (%0d,%0d) blue %0d, expected %0d",
                         px.column, px.row, word[24:17], px.blue));
      if (word[31:25] !== '0)
        report($sformatf("pixel (%0d,%0d) padding bits %b not zero",
                         px.column, px.row, word[31:25]));
    endtask

    task px_leftover(pixel_colour_t px);
      report($sformatf("pixel (%0d,%0d) never produced a result", px.column, px.row));
    endtask

    task close();
      while (pending_pixels.size() != 0) begin
        px_leftover(pending_pixels.pop_front());
      end
    endtask
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          s_tvalid    = 1'b0;
  logic                          s_tready;
  logic [23:0]                   s_tdata     = '0;   // column[11:0], row[23:12]
  logic                          m_tvalid;
  logic                          m_tready    = 1'b0;
  logic [31:0]                   m_tdata;            // in_set[0], red[8:1], green[16:9],
                                                     // blue[24:17]
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [jsp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [jsp_pkg::CFG_DAT_W-1:0] cfg_data_i  = '0;

  pixel_scoreboard sb;
  int gap_max;
  int stall_max;
  int settings_used;
  int cycle_count;

  julia_set_pixel u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // One register write on the configuration channel.
  task write_reg(logic [jsp_pkg::CFG_IDX_W-1:0] index, logic [jsp_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(index, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task apply_window(logic [31:0] w, logic [31:0] h, logic [31:0] rl, logic [31:0] rh,
                    logic [31:0] il, logic [31:0] ih);
    write_reg(jsp_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(jsp_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(jsp_pkg::CFG_REAL_LOW, rl);
    write_reg(jsp_pkg::CFG_REAL_HIGH, rh);
    write_reg(jsp_pkg::CFG_IMAG_LOW, il);
    write_reg(jsp_pkg::CFG_IMAG_HIGH, ih);
    settings_used++;
  endtask

  // Offer one pixel after a random gap and wait for it to be taken.
  task send_pixel(logic [jsp_pkg::PIX_W-1:0] column, logic [jsp_pkg::PIX_W-1:0] row);
    int gap;
    gap = $urandom_range(gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {row, column};
    do @(posedge clk_i); while (!s_tready);
    sb.note_pixel(column, row);
  endtask

  // Stop offering pixels and wait until every expected colour has come back.
  task wait_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  function int pick_range(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function logic [31:0] pick_side();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 6) return pick_range(2, 48);
    if (sel == 7) return ($urandom_range(1) == 0) ? SIDE_LIMIT : pick_range(2, SIDE_LIMIT);
    if (sel == 8) return $urandom();
    return $urandom_range(1);
  endfunction

  // Mostly pixels inside the image, sometimes any 12-bit position.
  function logic [jsp_pkg::PIX_W-1:0] pick_pos(logic [jsp_pkg::SIDE_W-1:0] raw);
    if ($urandom_range(6) == 0) return jsp_pkg::PIX_W'($urandom_range(4095));
    return jsp_pkg::PIX_W'($urandom_range(sb.eff_side(raw) - 1));
  endfunction

  // Random window: mostly around the set, also tiny, flat and full-range ones.
  task random_setting();
    int unsigned sel;
    int          rl;
    int          rh;
    int          il;
    int          ih;
    int          ctr;
    sel = $urandom_range(9);
    if (sel <= 5) begin
      rl = pick_range(-2 * Q_ONE, Q_ONE / 4);
      rh = pick_range(-Q_ONE / 4, 2 * Q_ONE);
      il = pick_range(-2 * Q_ONE, Q_ONE / 4);
      ih = pick_range(-Q_ONE / 4, 2 * Q_ONE);
      if ($urandom_range(3) == 0) begin
        ctr = rl; rl = rh; rh = ctr;
      end
      if ($urandom_range(3) == 0) begin
        ctr = il; il = ih; ih = ctr;
      end
    end else if (sel == 6) begin
      ctr = pick_range(-Q_ONE, Q_ONE);
      rl  = ctr - pick_range(0, Q_ONE / 20);
      rh  = ctr + pick_range(0, Q_ONE / 20);
      ctr = pick_range(-Q_ONE, Q_ONE);
      il  = ctr - pick_range(0, Q_ONE / 20);
      ih  = ctr + pick_range(0, Q_ONE / 20);
    end else if (sel <= 8) begin
      rl = $urandom();
      rh = $urandom();
      il = $urandom();
      ih = $urandom();
    end else begin
      rl = pick_range(-3 * Q_ONE / 2, 3 * Q_ONE / 2);
      rh = rl;
      il = pick_range(-3 * Q_ONE / 2, 3 * Q_ONE / 2);
      ih = il;
    end
    apply_window(pick_side(), pick_side(), rl, rh, il, ih);
  endtask

  // Colour results are taken with a random stall before each item.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = $urandom_range(stall_max);
      repeat (stall) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      sb.check_pixel(m_tdata);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d pixels outstanding.",
             cycle_count, sb.pending_count());
    $display("FAILURE");
    $finish;
  end

  // Main sequence: reset, directed settings, then random settings.
  initial begin
    int phase_len;
    int phase_no;
    logic [jsp_pkg::PIX_W-1:0] col;
    logic [jsp_pkg::PIX_W-1:0] row;
    sb            = new();
    gap_max       = MAX_IDLE;
    stall_max     = MAX_IDLE;
    settings_used = 1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default window after reset, corners, centre and pixels beyond the image.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd999, 12'd999);
    send_pixel(12'd500, 12'd500);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd123, 12'd777);
    wait_drained();

    // Sizes below two and a mirrored real axis.
    apply_window(32'd0, 32'd1, 32'sd1572864, -32'sd1572864, -32'sd1572864, 32'sd1572864);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    wait_drained();

    // Oversized image and the widest window, mirrored in the imaginary axis.
    apply_window(32'd8191, 32'd4097, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd4095, 12'd0);
    wait_drained();

    // Window collapsed onto the origin: every pixel starts at zero.
    apply_window(32'hFFFF_E002, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    wait_drained();

    // Random settings, each followed by a batch of pixels.
    phase_no = 0;
    while (sb.pixels_seen < TARGET_PIXELS) begin
      random_setting();
      gap_max   = ($urandom_range(3) == 0) ? 0 : MAX_IDLE;
      stall_max = ($urandom_range(3) == 0) ? 0 : MAX_IDLE;
      phase_len = $urandom_range(28, 16);
      for (int i = 0; i < phase_len; i++) begin
        col = pick_pos(sb.width_reg);
        row = pick_pos(sb.height_reg);
        send_pixel(col, row);
        if (phase_no % 5 == 2 && i == phase_len / 2) wait_drained();
      end
      wait_drained();
      phase_no++;
    end

    sb.close();
    $display("Checked %0d pixels under %0d window settings: %0d inside the set, %0d escaped.",
             sb.pixels_seen, settings_used, sb.inside_seen,
             sb.pixels_seen - sb.inside_seen);
    $display("Mismatches counted: %0d.", sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== julia_set_pixel.f =====
hdl/jsp_pkg.sv
hdl/jsp_ctrl.sv
hdl/jsp_dpath.sv
hdl/julia_set_pixel.sv
verif/tb_top.sv
